>>> hw/rtl/mexp_pkg.sv
// Package for the modular exponentiation core.
// Holds the controller state type, register indexes and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EBIT,
        ST_MULP,
        ST_SQLOAD,
        ST_MULS,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath and output stage.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_load;
        logic mul_sq;
        logic mul_step;
        logic e_shift;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic div_last;
        logic e_bit0;
        logic e_last;
        logic mul_last;
    } dp_status_t;

endpackage

>>> hw/rtl/modular_exponentiation_core.sv
// Order of work: the base is first reduced by the modulus; then each exponent bit, lowest first,
// takes a modular multiply when it is set and then a squaring (the top bit skips the squaring);
// last the result is written to the output register. A zero modulus goes straight to the output
// with an error. One base at a time: the next is taken only after the result is registered, and
// later while an earlier result is still stalled in the output register.
// Reset (rst_n, asynchronous, active low) sets modulus to 1 and exponent to 0, empties the output.
`timescale 1ns / 1ps

// Top level of the modular exponentiation core.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp; holds the configuration and output registers.
module modular_exponentiation_core #(
    parameter int WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]               cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [WIDTH-1:0]               base,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [WIDTH-1:0]               power,
    output logic                           error
);

    import mexp_pkg::*;

    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic [WIDTH-1:0] exponent_reg, exponent_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] power_reg, power_next;
    logic             error_reg, error_next;

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic             busy;
    logic             out_free;
    logic [WIDTH-1:0] prod;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .modulus  (modulus_reg),
        .exponent (exponent_reg),
        .base     (base),
        .status   (status),
        .prod     (prod)
    );

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODULUS:  modulus_next  = cfg_data;
                REG_EXPONENT: exponent_next = cfg_data;
                default:      ;
            endcase
        end
    end

    // A zero modulus reports an error with a zero result.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        power_next     = power_reg;
        error_next     = error_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            power_next     = status.n_zero ? '0 : prod;
            error_next     = status.n_zero;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= WIDTH'(1);
            exponent_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        power_reg <= power_next;
        error_reg <= error_next;
    end

    assign in_stall  = busy;
    assign out_valid = out_valid_reg;
    assign power     = power_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("Finished result did not reach the output.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> power == '0)
        else $error("Error result carries a nonzero power.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Core did not hold off input after a transfer.");
`endif

endmodule

>>> hw/rtl/mexp_dp.sv
// Datapath of the modular exponentiation core: base reduction, shift-and-add modular product.
// Depends on mexp_pkg for the command and status structs.
`timescale 1ns / 1ps

module mexp_dp #(
    parameter int WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mexp_pkg::ctrl_cmd_t   cmd,
    input  logic [WIDTH-1:0]      modulus,
    input  logic [WIDTH-1:0]      exponent,
    input  logic [WIDTH-1:0]      base,
    output mexp_pkg::dp_status_t  status,
    output logic [WIDTH-1:0]      prod
);

    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] prod_reg, prod_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] dbl_reg, dbl_next;
    logic [WIDTH-1:0] mul_reg, mul_next;
    logic             sq_reg, sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [WIDTH:0]   n_ext;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_red;
    logic [WIDTH:0]   acc_sum;
    logic [WIDTH:0]   acc_red;
    logic [WIDTH-1:0] acc_step;
    logic [WIDTH:0]   dbl_sum;
    logic [WIDTH:0]   dbl_red;

    // Each sum is below twice the modulus, so one compare and subtract reduces it.
    always_comb
    begin
        n_ext     = {1'b0, n_reg};
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        rem_red   = (rem_shift >= n_ext) ? (rem_shift - n_ext) : rem_shift;
        acc_sum   = {1'b0, acc_reg} + {1'b0, dbl_reg};
        acc_red   = (acc_sum >= n_ext) ? (acc_sum - n_ext) : acc_sum;
        acc_step  = mul_reg[0] ? acc_red[WIDTH-1:0] : acc_reg;
        dbl_sum   = {dbl_reg, 1'b0};
        dbl_red   = (dbl_sum >= n_ext) ? (dbl_sum - n_ext) : dbl_sum;
    end

    always_comb
    begin
        n_next    = n_reg;
        e_next    = e_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        dbl_next  = dbl_reg;
        mul_next  = mul_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            n_next    = modulus;
            e_next    = exponent;
            quo_next  = base;
            rem_next  = '0;
            prod_next = WIDTH'(1);
            cnt_next  = CNT_W'(WIDTH - 1);
        end
        if (cmd.div_step)
        begin
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            rem_next = rem_red[WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                a_next = rem_red[WIDTH-1:0];
            end
        end
        if (cmd.mul_load)
        begin
            acc_next = '0;
            dbl_next = a_reg;
            mul_next = cmd.mul_sq ? a_reg : prod_reg;
            sq_next  = cmd.mul_sq;
        end
        if (cmd.mul_step)
        begin
            acc_next = acc_step;
            dbl_next = dbl_red[WIDTH-1:0];
            mul_next = {1'b0, mul_reg[WIDTH-1:1]};
            if (mul_reg[WIDTH-1:1] == '0)
            begin
                if (sq_reg)
                begin
                    a_next = acc_step;
                end
                else
                begin
                    prod_next = acc_step;
                end
            end
        end
        if (cmd.e_shift)
        begin
            e_next = {1'b0, e_reg[WIDTH-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        e_reg    <= e_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        dbl_reg  <= dbl_next;
        mul_reg  <= mul_next;
        sq_reg   <= sq_next;
    end

    assign status.n_zero   = (n_reg == '0);
    assign status.div_last = (cnt_reg == '0);
    assign status.e_bit0   = e_reg[0];
    assign status.e_last   = (e_reg[WIDTH-1:1] == '0);
    assign status.mul_last = (mul_reg[WIDTH-1:1] == '0);
    assign prod            = prod_reg;

`ifndef SYNTHESIS
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step && !status.n_zero |=> acc_reg < n_reg)
        else $error("Accumulator left unreduced after a product step.");

    a_dbl_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_step && !status.n_zero |=> dbl_reg < n_reg)
        else $error("Doubled operand left unreduced after a product step.");

    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && !status.n_zero |=> rem_reg < n_reg)
        else $error("Remainder of the base reduction is not below the modulus.");
`endif

endmodule

>>> hw/rtl/mexp_ctrl.sv
// Controller state machine of the modular exponentiation core.
// Depends on mexp_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_free,
    input  mexp_pkg::dp_status_t  status,
    output mexp_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);

    import mexp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.n_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.div_last)
                begin
                    state_next = ST_EBIT;
                end
            end
            ST_EBIT:
            begin
                state_next = status.e_bit0 ? ST_MULP : ST_SQLOAD;
            end
            ST_MULP:
            begin
                if (status.mul_last)
                begin
                    state_next = ST_SQLOAD;
                end
            end
            ST_SQLOAD:
            begin
                state_next = status.e_last ? ST_FINISH : ST_MULS;
            end
            ST_MULS:
            begin
                if (status.mul_last)
                begin
                    state_next = ST_EBIT;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_valid;
            end
            ST_REDUCE:
            begin
                cmd.div_step = !status.n_zero;
            end
            ST_EBIT:
            begin
                cmd.mul_load = status.e_bit0;
            end
            ST_MULP:
            begin
                cmd.mul_step = 1'b1;
            end
            ST_SQLOAD:
            begin
                cmd.mul_load = !status.e_last;
                cmd.mul_sq   = 1'b1;
            end
            ST_MULS:
            begin
                cmd.mul_step = 1'b1;
                cmd.e_shift  = status.mul_last;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("Result written while the output register was still full.");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_REDUCE)
        else $error("Accepted base did not start a reduction.");

    a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REDUCE && status.n_zero |-> !cmd.div_step)
        else $error("Reduction stepped with a zero modulus.");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for modular_exponentiation_core: drives bases, programs modulus
// and exponent, and checks each power against a square-and-multiply predictor.
// Depends on mexp_pkg and modular_exponentiation_core only.
`timescale 1ns / 1ps

module tb;

    import mexp_pkg::*;

    localparam int WIDTH = 32;
    localparam int SETTLE_CYCLES = 2300;

    typedef struct packed {
        logic [WIDTH-1:0] power;
        logic             error;
    } power_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
    logic [WIDTH-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [WIDTH-1:0]     base = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WIDTH-1:0]     power;
    logic                 error;

    // Local copy of the programmed registers, at their reset values.
    logic [WIDTH-1:0] modulus_cfg = 1;
    logic [WIDTH-1:0] exponent_cfg = '0;

    logic [WIDTH-1:0] pending_bases[$];
    power_result_t    expected_powers[$];
    power_result_t    oldest_power;

    int send_idle_pct = 33;
    int recv_idle_pct = 79;
    int bases_queued = 0;
    int bases_accepted = 0;
    int settings_used = 1;
    int zero_mod_settings = 0;
    int mismatch_count = 0;

    modular_exponentiation_core #(
        .WIDTH(WIDTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .base     (base),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power    (power),
        .error    (error)
    );

    always #5 clk = ~clk;

    // Right-to-left square-and-multiply with full-width products reduced by the modulus.
    // A zero exponent leaves the product at 1 without any reduction.
    function automatic power_result_t predict_power(input logic [WIDTH-1:0] b);
        logic [63:0]      prod;
        logic [63:0]      sq;
        logic [WIDTH-1:0] e;
        power_result_t    r;
        r.power = '0;
        r.error = 1'b1;
        if (modulus_cfg == '0)
        begin
            return r;
        end
        prod = 64'd1;
        sq = {32'd0, b};
        e = exponent_cfg;
        do
        begin
            if (e[0])
            begin
                prod = (prod * sq) % modulus_cfg;
            end
            sq = (sq * sq) % modulus_cfg;
            e = e >> 1;
        end
        while (e != '0);
        r.power = prod[WIDTH-1:0];
        r.error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Sender: a transfer completes on valid and not stall; the next base is presented only
    // once the current one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            base <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_powers.push_back(predict_power(base));
                bases_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    base <= pending_bases.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall, and every result transfer is checked against the oldest
    // prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_powers.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result power=%h error=%b",
                                              power, error));
                end
                else
                begin
                    oldest_power = expected_powers.pop_front();
                    if (power !== oldest_power.power)
                    begin
                        report_mismatch($sformatf("power %h, predicted %h",
                                                  power, oldest_power.power));
                    end
                    if (error !== oldest_power.error)
                    begin
                        report_mismatch($sformatf("error %b, predicted %b",
                                                  error, oldest_power.error));
                    end
                end
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WIDTH-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MODULUS)
        begin
            modulus_cfg = value;
        end
        else
        begin
            exponent_cfg = value;
        end
    endtask

    task automatic configure(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] e);
        write_register(REG_MODULUS, n);
        write_register(REG_EXPONENT, e);
        settings_used++;
        if (n == '0)
        begin
            zero_mod_settings++;
        end
        @(negedge clk);
    endtask

    function automatic void queue_base(input logic [WIDTH-1:0] b);
        pending_bases.push_back(b);
        bases_queued++;
    endfunction

    // Waits until every queued base has been taken and every result has come back.
    task automatic drain();
        while (bases_accepted != bases_queued || expected_powers.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [WIDTH-1:0] pick_modulus();
        case ($urandom_range(7))
            0: return '0;
            1: return $urandom_range(16, 1);
            2: return $urandom | 32'h8000_0000;
            3: return 32'hffff_ffff - $urandom_range(15);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_exponent();
        case ($urandom_range(7))
            0: return '0;
            1: return $urandom_range(15, 1);
            2: return $urandom;
            3: return $urandom | 32'h8000_0000;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // Half full-range random bases, with zero, one, all ones and values around the modulus mixed in.
    function automatic logic [WIDTH-1:0] pick_base();
        case ($urandom_range(11))
            0: return '0;
            1: return 1;
            2: return modulus_cfg - 1;
            3: return modulus_cfg;
            4: return '1;
            5: return modulus_cfg + $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers still at reset: exponent zero gives 1 even for a modulus of 1.
        queue_base('0);
        queue_base('1);
        drain();
        // Zero modulus flags an error whatever the exponent.
        configure(0, 0);
        queue_base('0);
        queue_base('1);
        drain();
        configure(0, '1);
        queue_base(32'h1234_5678);
        queue_base('1);
        drain();
        configure(1, 0);
        queue_base(9);
        drain();
        configure(1, 5);
        queue_base(7);
        queue_base('1);
        drain();
        configure(2, 1);
        queue_base('1);
        queue_base(2);
        drain();
        configure('1, '1);
        queue_base('0);
        queue_base(1);
        queue_base('1);
        queue_base(32'hffff_fffe);
        queue_base(2);
        drain();
        // Bases at and above the modulus must be reduced first.
        configure(32'hffff_fffb, 1);
        queue_base('1);
        queue_base(32'hffff_fffb);
        drain();
        configure(32'h8000_0000, 32'h8000_0000);
        queue_base(3);
        queue_base('1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 33;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(pick_modulus(), pick_exponent());
            for (int i = 0; i < 21; i++)
            begin
                queue_base(pick_base());
                // Hold the sender back until the core has returned everything so far.
                if (p == 5 && i == 10)
                begin
                    drain();
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d bases over %0d modulus and exponent settings,",
                 bases_accepted, settings_used);
        $display("%0d of them with a zero modulus; %0d mismatches seen.",
                 zero_mod_settings, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Timed out with %0d results outstanding.", expected_powers.size());
        $display("FAILURE");
        $finish;
    end

endmodule
